// ----- hw/rtl/nfpa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and control/status types of the next-fit page allocator.
// Depends on nothing; every other file of the block imports it.
package nfpa_pkg;

  // Page table geometry.
  localparam int PAGES      = 1024;
  localparam int PAGE_SHIFT = 9;
  localparam int PAGE_AW    = $clog2(PAGES);      // page index width
  localparam int CNT_W      = PAGE_AW + 1;        // holds a page count up to PAGES
  localparam int ENT_W      = PAGE_AW + 1;        // used flag on top of owner page

  // Field widths of the request and result items.
  localparam int CMD_W  = 2;
  localparam int SIZE_W = 20;
  localparam int OFF_W  = 19;
  localparam int REQ_W  = SIZE_W - PAGE_SHIFT + 1; // rounded-up page count of a size
  localparam int BYTE_W = CNT_W + PAGE_SHIFT;      // byte span of a page count

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Which value set the result register takes.
  typedef enum logic [1:0] {
    RES_FAIL  = 2'd0,
    RES_ALLOC = 2'd1,
    RES_WALK  = 2'd2,
    RES_NONE  = 2'd3
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr_en;
    logic     accept;
    logic     scan_start;
    logic     scan_wrap;
    logic     scan_run;
    logic     zero_pick;
    logic     mark_en;
    logic     cursor_upd;
    logic     look_rd;
    logic     load_j;
    logic     walk_rd;
    logic     walk_step;
    logic     load_result;
    res_sel_e res_sel;
  } nfpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             clr_last;
    logic             req_ok;
    logic             req_zero;
    logic             scan_hit;
    logic             scan_done;
    logic             mark_last;
    logic             look_ok;
    logic             j_in_table;
    logic             walk_match;
  } nfpa_status_t;

endpackage

// ----- hw/rtl/nfpa_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the page allocator: valid/ready plus command payload.
// Depends on nfpa_pkg.
interface nfpa_req_if;
  import nfpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFF_W-1:0]  byte_offset;

  modport source (output valid, command, size_bytes, byte_offset, input ready);
  modport sink   (input valid, command, size_bytes, byte_offset, output ready);
endinterface

// ----- hw/rtl/nfpa_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the page allocator: valid/ready plus result payload.
// Depends on nfpa_pkg.
interface nfpa_rsp_if;
  import nfpa_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [OFF_W-1:0] result_offset;
  logic [CNT_W-1:0] page_total;
  logic             size_fits;

  modport source (output valid, status, result_offset, page_total, size_fits, input ready);
  modport sink   (input valid, status, result_offset, page_total, size_fits, output ready);
endinterface

// ----- hw/rtl/nfpa_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel of the page allocator: the pages_in_use register.
// Depends on nfpa_pkg.
interface nfpa_cfg_if;
  import nfpa_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] pages_in_use;

  modport source (output valid, pages_in_use, input ready);
  modport sink   (input valid, pages_in_use, output ready);
endinterface

// ----- hw/rtl/nfpa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the page allocator: clearing pass, dispatch, scan, mark and walk.
// Depends on nfpa_pkg; drives the datapath through nfpa_cmd_t.
module nfpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  nfpa_pkg::nfpa_status_t st_i,
  output nfpa_pkg::nfpa_cmd_t    cmd_o
);
  import nfpa_pkg::*;

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_DISPATCH = 11'b000_0000_0100,
    ST_SCAN_F   = 11'b000_0000_1000,
    ST_SCAN_W   = 11'b000_0001_0000,
    ST_MARK     = 11'b000_0010_0000,
    ST_FINISH   = 11'b000_0100_0000,
    ST_W_OWN    = 11'b000_1000_0000,
    ST_W_RD     = 11'b001_0000_0000,
    ST_W_EV     = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    res_sel_d   = res_sel_q;
    cmd_o       = '0;
    cmd_o.res_sel = res_sel_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (st_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st_i.op == OP_ALLOC) begin
          if (!st_i.req_ok) begin
            res_sel_d = RES_FAIL;
            state_d   = ST_DONE;
          end else if (st_i.req_zero) begin
            cmd_o.zero_pick = 1'b1;
            state_d         = ST_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN_F;
          end
        end else if (st_i.op == OP_FREE || st_i.op == OP_QUERY) begin
          res_sel_d = RES_WALK;
          if (st_i.look_ok) begin
            cmd_o.look_rd = 1'b1;
            state_d       = ST_W_OWN;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          res_sel_d = RES_NONE;
          state_d   = ST_DONE;
        end
      end
      ST_SCAN_F: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_hit) begin
          state_d = ST_MARK;
        end else if (st_i.scan_done) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_wrap  = 1'b1;
          state_d          = ST_SCAN_W;
        end
      end
      ST_SCAN_W: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_hit) begin
          state_d = ST_MARK;
        end else if (st_i.scan_done) begin
          res_sel_d = RES_FAIL;
          state_d   = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd_o.mark_en = 1'b1;
        if (st_i.mark_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.cursor_upd = 1'b1;
        res_sel_d        = RES_ALLOC;
        state_d          = ST_DONE;
      end
      ST_W_OWN: begin
        cmd_o.load_j = 1'b1;
        state_d      = ST_W_RD;
      end
      ST_W_RD: begin
        if (st_i.j_in_table) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = ST_W_EV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_W_EV: begin
        if (st_i.walk_match) begin
          cmd_o.walk_step = 1'b1;
          state_d         = ST_W_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_sel_q   <= RES_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/nfpa_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the page allocator: page table memory, cursor, scan and walk logic,
// configuration register and result register. Depends on nfpa_pkg.
module nfpa_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nfpa_pkg::nfpa_cmd_t             cmd_i,
  output nfpa_pkg::nfpa_status_t          st_o,
  input  logic [nfpa_pkg::CMD_W-1:0]     command_i,
  input  logic [nfpa_pkg::SIZE_W-1:0]    size_bytes_i,
  input  logic [nfpa_pkg::OFF_W-1:0]     byte_offset_i,
  input  logic                           cfg_we_i,
  input  logic [nfpa_pkg::CNT_W-1:0]     cfg_pages_i,
  output logic                           status_o,
  output logic [nfpa_pkg::OFF_W-1:0]     result_offset_o,
  output logic [nfpa_pkg::CNT_W-1:0]     page_total_o,
  output logic                           size_fits_o
);
  import nfpa_pkg::*;

  // Page table: used flag in the top bit, owner start page below it.
  logic [ENT_W-1:0]   page_mem [PAGES];
  logic [ENT_W-1:0]   rd_data_q;
  logic [PAGE_AW-1:0] rd_addr;
  logic               mem_we;
  logic [PAGE_AW-1:0] mem_wa;
  logic [ENT_W-1:0]   mem_wd;

  logic [CMD_W-1:0]   cmd_q;
  logic [SIZE_W-1:0]  size_q;
  logic [OFF_W-1:0]   off_q;
  logic [CNT_W-1:0]   pic_q;
  logic [CNT_W-1:0]   cursor_q;
  logic [PAGE_AW-1:0] clr_q;

  logic [CNT_W-1:0]   addr_q, end_q, run_q, found_q, k_q, j_q, count_q;
  logic [PAGE_AW-1:0] pg_q;
  logic               rdv_q, hit_q;

  logic               res_status_q, res_fits_q;
  logic [OFF_W-1:0]   res_off_q;
  logic [CNT_W-1:0]   res_total_q;

  logic [CNT_W-1:0]   pc, cur_min, run_inc, req_c, mark_addr;
  logic [REQ_W-1:0]   req, look;
  logic               scan_issue, walk_match, fits;
  logic [BYTE_W-1:0]  owner_bytes, off_bytes, count_bytes, size_ext;

  // Managed table size and clamped cursor.
  assign pc      = (pic_q < CNT_W'(PAGES)) ? pic_q : CNT_W'(PAGES);
  assign cur_min = (cursor_q < pc) ? cursor_q : pc;

  // Byte size rounded up to pages, and the page that holds the owner of an offset.
  assign req  = REQ_W'(size_q >> PAGE_SHIFT) + REQ_W'(|size_q[PAGE_SHIFT-1:0]);
  assign look = REQ_W'(off_q >> PAGE_SHIFT) + REQ_W'(|off_q[PAGE_SHIFT-1:0]);
  assign req_c = req[CNT_W-1:0];

  assign scan_issue = cmd_i.scan_run && (addr_q < end_q) && !hit_q;
  assign run_inc    = run_q + CNT_W'(1);
  assign mark_addr  = found_q + k_q;

  assign owner_bytes = BYTE_W'({rd_data_q[PAGE_AW-1:0], {PAGE_SHIFT{1'b0}}});
  assign off_bytes   = BYTE_W'(off_q);
  assign walk_match  = rd_data_q[PAGE_AW] && (owner_bytes == off_bytes);
  assign count_bytes = {count_q, {PAGE_SHIFT{1'b0}}};
  assign size_ext    = BYTE_W'(size_q);
  assign fits        = (cmd_q == OP_QUERY) && (size_ext <= count_bytes);

  // Memory port selection.
  always_comb begin
    if (cmd_i.look_rd) begin
      rd_addr = look[PAGE_AW-1:0];
    end else if (cmd_i.walk_rd) begin
      rd_addr = j_q[PAGE_AW-1:0];
    end else begin
      rd_addr = addr_q[PAGE_AW-1:0];
    end
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    if (cmd_i.clr_en) begin
      mem_we = 1'b1;
    end else if (cmd_i.mark_en) begin
      mem_we = 1'b1;
      mem_wa = mark_addr[PAGE_AW-1:0];
      mem_wd = {1'b1, found_q[PAGE_AW-1:0]};
    end else if (cmd_i.walk_step && (cmd_q == OP_FREE)) begin
      mem_we = 1'b1;
      mem_wa = j_q[PAGE_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= page_mem[rd_addr];
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pic_q    <= CNT_W'(PAGES);
      cursor_q <= '0;
      clr_q    <= '0;
      rdv_q    <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pic_q <= cfg_pages_i;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + PAGE_AW'(1);
      end
      if (cmd_i.cursor_upd) begin
        cursor_q <= found_q + req_c;
      end
      if (cmd_i.scan_start) begin
        rdv_q <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rdv_q <= scan_issue;
        if (rdv_q && !hit_q && !rd_data_q[PAGE_AW] && (run_inc == req_c)) begin
          hit_q <= 1'b1;
        end
      end else begin
        rdv_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      size_q  <= size_bytes_i;
      off_q   <= byte_offset_i;
      count_q <= '0;
    end
    if (cmd_i.scan_start) begin
      addr_q <= cmd_i.scan_wrap ? '0 : cursor_q;
      end_q  <= cmd_i.scan_wrap ? cur_min : pc;
      run_q  <= '0;
      k_q    <= '0;
    end else if (cmd_i.scan_run) begin
      if (scan_issue) begin
        addr_q <= addr_q + CNT_W'(1);
      end
      pg_q <= addr_q[PAGE_AW-1:0];
      if (rdv_q && !hit_q) begin
        if (!rd_data_q[PAGE_AW]) begin
          run_q <= run_inc;
          if (run_inc == req_c) begin
            found_q <= CNT_W'(pg_q) + CNT_W'(1) - req_c;
          end
        end else begin
          run_q <= '0;
        end
      end
    end
    if (cmd_i.zero_pick) begin
      found_q <= (cursor_q <= pc) ? cursor_q : '0;
    end
    if (cmd_i.mark_en) begin
      k_q <= k_q + CNT_W'(1);
    end
    if (cmd_i.load_j) begin
      j_q <= CNT_W'(rd_data_q[PAGE_AW-1:0]);
    end
    if (cmd_i.walk_step) begin
      j_q     <= j_q + CNT_W'(1);
      count_q <= count_q + CNT_W'(1);
    end
    if (cmd_i.load_result) begin
      case (cmd_i.res_sel)
        RES_FAIL: begin
          res_status_q <= 1'b1;
          res_off_q    <= '0;
          res_total_q  <= '0;
          res_fits_q   <= 1'b0;
        end
        RES_ALLOC: begin
          res_status_q <= 1'b0;
          res_off_q    <= OFF_W'({found_q, {PAGE_SHIFT{1'b0}}});
          res_total_q  <= req_c;
          res_fits_q   <= 1'b0;
        end
        RES_WALK: begin
          res_status_q <= 1'b0;
          res_off_q    <= '0;
          res_total_q  <= count_q;
          res_fits_q   <= fits;
        end
        default: begin
          res_status_q <= 1'b0;
          res_off_q    <= '0;
          res_total_q  <= '0;
          res_fits_q   <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    st_o.op         = cmd_q;
    st_o.clr_last   = (clr_q == PAGE_AW'(PAGES - 1));
    st_o.req_ok     = (req <= REQ_W'(pc));
    st_o.req_zero   = (req == '0);
    st_o.scan_hit   = hit_q;
    st_o.scan_done  = !hit_q && !rdv_q && !(addr_q < end_q);
    st_o.mark_last  = ((k_q + CNT_W'(1)) == req_c);
    st_o.look_ok    = (look < REQ_W'(pc));
    st_o.j_in_table = (j_q < pc);
    st_o.walk_match = walk_match;
  end

  assign status_o        = res_status_q;
  assign result_offset_o = res_off_q;
  assign page_total_o    = res_total_q;
  assign size_fits_o     = res_fits_q;

endmodule

// ----- hw/rtl/next_fit_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the next-fit page allocator: controller plus datapath.
// Depends on nfpa_pkg, nfpa_req_if, nfpa_rsp_if, nfpa_cfg_if, nfpa_ctrl and nfpa_datapath.

// The block manages a table of 512-byte pages and serves one request at a time;
// each request gives exactly one result transfer. After reset a clearing pass
// writes every one of the 1024 table entries, one per cycle, so the request
// channel is not ready until that pass is over; configuration writes are taken
// at any time. Every request passes through accepting, dispatching and loading
// the result. An allocation that cannot fit in the table adds no further step,
// and a zero-size allocation adds only the cursor update. Any other allocation
// runs the next-fit scan (forward from the cursor, then from page 0): each pass
// reads the pages of its range in turn until a run fits, and a found run is
// then marked page by page before the cursor update. So the cost of an
// allocation follows the fragmentation of the table. A free or a query whose
// offset maps outside the table takes only the accept, dispatch and result
// steps; otherwise it fetches the owner page, then the walk reads an entry and
// then checks (and for a free clears) it, page by page, and ends at the table
// end or at a page it does not own. All of these steps are paced by the single
// read port of the page table memory. The result register lets the next request
// be taken while a result still waits on the result channel; a request stalls
// in its result cycle only while the previous result is still waiting.
// Change pages_in_use only while no request is in flight.
module next_fit_page_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfpa_req_if.sink   req_i,
  nfpa_rsp_if.source rsp_o,
  nfpa_cfg_if.sink   cfg_i
);
  import nfpa_pkg::*;

  nfpa_cmd_t    cmd;
  nfpa_status_t st;

  // The configuration register can always be written.
  assign cfg_i.ready = 1'b1;

  // The controller owns both handshakes and sequences the datapath.
  nfpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // The datapath holds the page table, cursor, search state and result register.
  nfpa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .command_i       (req_i.command),
    .size_bytes_i    (req_i.size_bytes),
    .byte_offset_i   (req_i.byte_offset),
    .cfg_we_i        (cfg_i.valid),
    .cfg_pages_i     (cfg_i.pages_in_use),
    .status_o        (rsp_o.status),
    .result_offset_o (rsp_o.result_offset),
    .page_total_o    (rsp_o.page_total),
    .size_fits_o     (rsp_o.size_fits)
  );

endmodule

// ----- tb/tb_next_fit_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of next_fit_page_allocator_unit: a directed table, then random phases.
// Depends on nfpa_pkg, the three channel interfaces and the allocator RTL.
module tb_next_fit_page_allocator_unit;
  import nfpa_pkg::*;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;
  localparam int   N_PHASES        = 9;

  // Command code the block does not define.
  localparam logic [CMD_W-1:0] OP_ILLEGAL = 2'd3;

  // One result item as it leaves the block.
  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] pages;
    logic             fits;
  } alloc_result_t;

  // One row of the directed table: a request, or a write of pages_in_use.
  typedef struct packed {
    logic              is_cfg;
    logic [CNT_W-1:0]  cfg_value;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
    logic              typed;
    alloc_result_t     want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nfpa_req_if req_bus ();
  nfpa_rsp_if rsp_bus ();
  nfpa_cfg_if cfg_bus ();

  next_fit_page_allocator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the page table, the cursor and the register.
  bit                 page_used  [PAGES];
  logic [PAGE_AW-1:0] page_owner [PAGES];
  int unsigned        next_page;
  logic [CNT_W-1:0]   pages_cfg;

  alloc_result_t    owed_results [$];
  logic [OFF_W-1:0] live_offsets [$];
  dir_row_t         dir_rows [$];
  int               mismatch_count = 0;
  bit               quiet_tail = 1'b0;

  // The table never grows past PAGES, whatever the register holds.
  function automatic int unsigned managed_pages();
    return (pages_cfg < PAGES) ? pages_cfg : PAGES;
  endfunction

  // Lowest page at or above lo that starts need free pages ending below hi.
  function automatic int first_free_run(input int unsigned lo, input int unsigned hi,
                                        input int unsigned need);
    int unsigned run;
    run = 0;
    if (lo > hi) return -1;
    if (need == 0) return int'(lo);
    for (int unsigned j = lo; j < hi; j++) begin
      if (!page_used[j]) begin
        run++;
        if (run == need) return int'(j + 1 - need);
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  // Count, and on a free also clear, the run of pages owned by byte offset off.
  function automatic int unsigned walk_allocation(input logic [OFF_W-1:0] off,
                                                  input bit clear_pages);
    int unsigned limit, look, j, count, owner_bytes;
    limit = managed_pages();
    look  = (off >> PAGE_SHIFT) + ((off[PAGE_SHIFT-1:0] != 0) ? 1 : 0);
    count = 0;
    if (look >= limit) return 0;
    j = page_owner[look];
    while (j < limit) begin
      owner_bytes = page_owner[j];
      if (!page_used[j] || ((owner_bytes << PAGE_SHIFT) != off)) break;
      if (clear_pages) begin
        page_used[j]  = 1'b0;
        page_owner[j] = '0;
      end
      count++;
      j++;
    end
    return count;
  endfunction

  // Applies one request to the shadow table and returns the result it owes.
  function automatic alloc_result_t serve_request(input logic [CMD_W-1:0] cmd,
                                                  input logic [SIZE_W-1:0] size,
                                                  input logic [OFF_W-1:0] off);
    alloc_result_t res;
    int unsigned   limit, need, count, start;
    int            found;
    res   = '0;
    limit = managed_pages();
    case (cmd)
      OP_ALLOC: begin
        need  = (size >> PAGE_SHIFT) + ((size[PAGE_SHIFT-1:0] != 0) ? 1 : 0);
        start = next_page;
        found = -1;
        if (need <= limit) begin
          found = first_free_run(start, limit, need);
          if (found < 0) found = first_free_run(0, (start < limit) ? start : limit, need);
        end
        if (found < 0) begin
          res.status = STATUS_NO_SPACE;
        end else begin
          for (int unsigned k = 0; k < need; k++) begin
            page_used[found + k]  = 1'b1;
            page_owner[found + k] = PAGE_AW'(found);
          end
          next_page  = found + need;
          // A zero-size request at the table end gives an offset that wraps to 0.
          res.offset = OFF_W'(found << PAGE_SHIFT);
          res.pages  = CNT_W'(need);
        end
      end
      OP_FREE: begin
        res.pages = CNT_W'(walk_allocation(off, 1'b1));
      end
      OP_QUERY: begin
        count     = walk_allocation(off, 1'b0);
        res.pages = CNT_W'(count);
        res.fits  = (size <= (count << PAGE_SHIFT));
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Hands one request to the block; the shadow model advances at the transfer.
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                               input logic [OFF_W-1:0] off, input bit typed,
                               input alloc_result_t typed_result,
                               output alloc_result_t owed);
    req_bus.valid       <= 1'b1;
    req_bus.command     <= cmd;
    req_bus.size_bytes  <= size;
    req_bus.byte_offset <= off;
    do @(posedge clk_i); while (!req_bus.ready);
    owed = serve_request(cmd, size, off);
    owed_results.push_back(typed ? typed_result : owed);
    if (cmd == OP_ALLOC && owed.status == STATUS_OK && owed.pages != 0)
      live_offsets.push_back(owed.offset);
  endtask

  // Random sender gap, none in the closing stretch.
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // The register only changes once every owed result has come back.
  task automatic write_pages(input logic [CNT_W-1:0] value);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.pages_in_use <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    pages_cfg = value;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic row_typed(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                           input logic [OFF_W-1:0] off, input logic status,
                           input int unsigned offset, input int unsigned pages,
                           input logic fits);
    dir_row_t row;
    row             = '0;
    row.cmd         = cmd;
    row.size        = size;
    row.off         = off;
    row.typed       = 1'b1;
    row.want.status = status;
    row.want.offset = OFF_W'(offset);
    row.want.pages  = CNT_W'(pages);
    row.want.fits   = fits;
    dir_rows.push_back(row);
  endtask

  task automatic row_modeled(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                             input logic [OFF_W-1:0] off);
    dir_row_t row;
    row      = '0;
    row.cmd  = cmd;
    row.size = size;
    row.off  = off;
    dir_rows.push_back(row);
  endtask

  task automatic row_config(input logic [CNT_W-1:0] value);
    dir_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    dir_rows.push_back(row);
  endtask

  // Result side: takes each result transfer, checks it against the oldest owed
  // result and drives ready with random stall bursts.
  initial begin : result_sink
    alloc_result_t want;
    int            stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result with nothing owed, page_total", rsp_bus.page_total, 0);
        end else begin
          want = owed_results.pop_front();
          if (rsp_bus.status !== want.status)
            flag_mismatch("status", rsp_bus.status, want.status);
          if (rsp_bus.result_offset !== want.offset)
            flag_mismatch("result_offset", rsp_bus.result_offset, want.offset);
          if (rsp_bus.page_total !== want.pages)
            flag_mismatch("page_total", rsp_bus.page_total, want.pages);
          if (rsp_bus.size_fits !== want.fits)
            flag_mismatch("size_fits", rsp_bus.size_fits, want.fits);
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet_tail && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      rsp_bus.ready <= (stall_left == 0);
    end
  end

  // Hard stop, several times the slowest legal run.
  initial begin : watchdog
    #400_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned   phase_pages [N_PHASES];
    int unsigned   phase_items [N_PHASES];
    alloc_result_t owed;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
    int unsigned   pc, pick, pages, span, roll;

    phase_pages = '{16, 1024, 40, 1, 1500, 64, 2, 300, 24};
    phase_items = '{150, 80, 150, 60, 60, 200, 80, 120, 450};
    rst_ni = 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.command      <= OP_ALLOC;
    req_bus.size_bytes   <= '0;
    req_bus.byte_offset  <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.pages_in_use <= 11'd1024;
    for (int i = 0; i < PAGES; i++) begin
      page_used[i]  = 1'b0;
      page_owner[i] = '0;
    end
    next_page = 0;
    pages_cfg = 11'd1024;

    // Fresh table of 1024 pages: lookups of nothing, the first allocations,
    // misaligned and out-of-table offsets, oversize requests, an unknown command.
    row_typed(OP_QUERY, 0, 0, STATUS_OK, 0, 0, 1'b1);
    row_typed(OP_ALLOC, 0, 0, STATUS_OK, 0, 0, 1'b0);
    row_typed(OP_ALLOC, 1, 0, STATUS_OK, 0, 1, 1'b0);
    row_typed(OP_ALLOC, 512, 0, STATUS_OK, 512, 1, 1'b0);
    row_typed(OP_ALLOC, 513, 0, STATUS_OK, 1024, 2, 1'b0);
    row_typed(OP_QUERY, 1024, 1024, STATUS_OK, 0, 2, 1'b1);
    row_typed(OP_QUERY, 5, 1023, STATUS_OK, 0, 0, 1'b0);
    row_typed(OP_QUERY, 20'hFFFFF, 19'h7FFFF, STATUS_OK, 0, 0, 1'b0);
    row_typed(OP_ALLOC, 524288, 0, STATUS_NO_SPACE, 0, 0, 1'b0);
    row_typed(OP_ILLEGAL, 20'hFFFFF, 19'h7FFFF, STATUS_OK, 0, 0, 1'b0);
    row_typed(OP_FREE, 0, 512, STATUS_OK, 0, 1, 1'b0);
    row_typed(OP_FREE, 0, 0, STATUS_OK, 0, 1, 1'b0);
    // Fill the table to its end; a zero-size request there wraps the offset,
    // then the search has to wrap to page 0 and finally finds nothing.
    row_typed(OP_ALLOC, 522240, 0, STATUS_OK, 2048, 1020, 1'b0);
    row_typed(OP_ALLOC, 0, 0, STATUS_OK, 0, 0, 1'b0);
    row_typed(OP_ALLOC, 1024, 0, STATUS_OK, 0, 2, 1'b0);
    row_typed(OP_ALLOC, 1, 0, STATUS_NO_SPACE, 0, 0, 1'b0);
    row_typed(OP_FREE, 0, 2048, STATUS_OK, 0, 1020, 1'b0);
    row_typed(OP_FREE, 0, 1024, STATUS_OK, 0, 2, 1'b0);
    row_typed(OP_FREE, 0, 0, STATUS_OK, 0, 2, 1'b0);
    // Park the cursor far out, then shrink the table below it.
    row_modeled(OP_ALLOC, 306176, 0);
    row_modeled(OP_FREE, 0, 1024);
    row_config(11'd8);
    row_modeled(OP_ALLOC, 0, 0);
    row_modeled(OP_ALLOC, 4096, 0);
    row_modeled(OP_FREE, 0, 0);
    row_config(11'd1);
    row_modeled(OP_ALLOC, 512, 0);
    row_modeled(OP_ALLOC, 1, 0);
    row_modeled(OP_FREE, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        req_bus.valid <= 1'b0;
        write_pages(dir_rows[r].cfg_value);
      end else begin
        issue_request(dir_rows[r].cmd, dir_rows[r].size, dir_rows[r].off,
                      dir_rows[r].typed, dir_rows[r].want, owed);
        sender_gap();
      end
    end

    // Random phases: mostly allocations with small sizes and frees or queries of
    // live allocations, the rest random noise over the whole field ranges.
    for (int p = 0; p < N_PHASES; p++) begin
      req_bus.valid <= 1'b0;
      write_pages(CNT_W'(phase_pages[p]));
      quiet_tail = (p == N_PHASES - 1);
      for (int n = 0; n < phase_items[p]; n++) begin
        pc   = managed_pages();
        roll = $urandom_range(0, 99);
        off  = OFF_W'($urandom());
        size = SIZE_W'($urandom());
        if (roll < 45) begin
          cmd  = OP_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            size = 0;
          end else if (pick < 95) begin
            pages = (pick < 85) ? $urandom_range(1, (pc < 8) ? pc : 8) : $urandom_range(1, pc);
            size  = SIZE_W'((pages << PAGE_SHIFT) - $urandom_range(0, 511));
          end
        end else if (roll < 90 && live_offsets.size() != 0) begin
          pick = $urandom_range(0, live_offsets.size() - 1);
          off  = live_offsets[pick];
          if (roll < 75) begin
            cmd = OP_FREE;
            live_offsets.delete(pick);
          end else begin
            // Sizes right around the byte span of the allocation.
            cmd  = OP_QUERY;
            span = walk_allocation(off, 1'b0) << PAGE_SHIFT;
            if ($urandom_range(0, 3) != 0)
              size = (span == 0) ? SIZE_W'($urandom_range(0, 1))
                                 : SIZE_W'(span + $urandom_range(0, 2) - 1);
          end
        end else begin
          cmd = CMD_W'($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 0)
            off = OFF_W'(($urandom_range(0, pc) << PAGE_SHIFT) + $urandom_range(0, 1));
        end
        issue_request(cmd, size, off, 1'b0, '0, owed);
        sender_gap();
      end
    end

    req_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/nfpa_pkg.sv
hw/rtl/nfpa_req_if.sv
hw/rtl/nfpa_rsp_if.sv
hw/rtl/nfpa_cfg_if.sv
hw/rtl/nfpa_ctrl.sv
hw/rtl/nfpa_datapath.sv
hw/rtl/next_fit_page_allocator_unit.sv
tb/tb_next_fit_page_allocator_unit.sv
